[rtl/core/bist_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bist_pkg
// Shared constants and types for the bounded integer set table.
// ----------------------------------------------------------------------------
package bist_pkg;

  // Table capacity and derived widths
  localparam int unsigned CAPACITY = 128;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OCNT_W   = 8;

  // Operation codes carried by one item
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_MOVE = 3'b100
  } state_e;

endpackage : bist_pkg
`default_nettype wire

[rtl/core/bist_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bist_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bist_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : bist_ram
`default_nettype wire

[rtl/core/bounded_integer_set_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_integer_set_table
// Set of distinct 32-bit integers held in a fixed table with a fill count.
// ----------------------------------------------------------------------------
// Each item is one operation: clear, add, remove or membership query. The
// item is taken at a rising edge with start high and busy low, and exactly
// one result follows, shown for one cycle under result_valid_o; the receiver
// cannot stall it, so it must sample the result in that cycle. A clear
// returns its result in the cycle after acceptance. Add, remove and query
// scan the stored entries linearly, one entry per cycle through the single
// read port of the entry memory, and stop at the first match. A remove that
// hits then goes through ST_MOVE, which moves the last entry into the freed
// slot with an extra read. busy drops in the cycle the result is shown, so
// the next item can be accepted at the very edge that ends the result cycle.
// entry_count_o holds the count after the last finished operation.
// ----------------------------------------------------------------------------
module bounded_integer_set_table import bist_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     result_valid_o,
  output logic                     was_present_o,
  output logic                     accepted_o,
  output logic [OCNT_W-1:0]        entry_count_o
);

  // Sequencer and control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic             res_valid_q, res_valid_d;
  logic             res_present_q, res_present_d;
  logic             res_acc_q, res_acc_d;

  // Item payload and scan bookkeeping
  action_e          act_q, act_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0] slot_q, slot_d;

  // Memory port signals
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic             hit;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W+OCNT_W-1:0] count_ext;

  bist_ram #(
    .Depth (CAPACITY),
    .Width (VAL_W)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A read issued last cycle comes back now; compare it against the item
  assign hit      = pend_q && (ram_rdata == value_q);
  assign last_idx = count_q - CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pend_d        = 1'b0;
    pend_idx_d    = pend_idx_q;
    slot_d        = slot_q;
    act_d         = act_q;
    value_d       = value_q;
    res_valid_d   = 1'b0;
    res_present_d = res_present_q;
    res_acc_d     = res_acc_q;
    ram_we        = 1'b0;
    ram_waddr     = slot_q;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d   = action_e'(action_i);
          value_d = value_i;
          if (action_e'(action_i) == ACT_CLEAR) begin
            // Drop every entry at once: the table is only read below the count
            count_d       = '0;
            res_valid_d   = 1'b1;
            res_present_d = 1'b0;
            res_acc_d     = 1'b0;
          end else begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit || !(idx_q < count_q)) begin
          // Scan finished: hit marks presence, pend_idx_q the matching slot
          case (act_q)
            ACT_ADD: begin
              res_valid_d   = 1'b1;
              res_present_d = hit;
              res_acc_d     = 1'b0;
              state_d       = ST_IDLE;
              if (!hit && (count_q < CNT_W'(CAPACITY))) begin
                // Append at the end of the filled region
                ram_we    = 1'b1;
                ram_waddr = count_q[IDX_W-1:0];
                ram_wdata = value_q;
                count_d   = count_q + CNT_W'(1);
                res_acc_d = 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                // Fetch the last entry to fill the freed slot
                ram_re    = 1'b1;
                ram_raddr = last_idx[IDX_W-1:0];
                slot_d    = pend_idx_q;
                state_d   = ST_MOVE;
              end else begin
                res_valid_d   = 1'b1;
                res_present_d = 1'b0;
                res_acc_d     = 1'b0;
                state_d       = ST_IDLE;
              end
            end
            default: begin
              res_valid_d   = 1'b1;
              res_present_d = hit;
              res_acc_d     = 1'b0;
              state_d       = ST_IDLE;
            end
          endcase
        end else begin
          // Advance the scan by one entry
          ram_re     = 1'b1;
          ram_raddr  = idx_q[IDX_W-1:0];
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IDX_W-1:0];
          idx_d      = idx_q + CNT_W'(1);
        end
      end

      ST_MOVE: begin
        // Write the last entry into the freed slot and shrink the count
        ram_we        = 1'b1;
        ram_waddr     = slot_q;
        ram_wdata     = ram_rdata;
        count_d       = last_idx;
        res_valid_d   = 1'b1;
        res_present_d = 1'b1;
        res_acc_d     = 1'b1;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      pend_q        <= 1'b0;
      res_valid_q   <= 1'b0;
      res_present_q <= 1'b0;
      res_acc_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      pend_q        <= pend_d;
      res_valid_q   <= res_valid_d;
      res_present_q <= res_present_d;
      res_acc_q     <= res_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    value_q    <= value_d;
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
  end

  // Report the count modulo 256
  assign count_ext = {{OCNT_W{1'b0}}, count_q};

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign was_present_o  = res_present_q;
  assign accepted_o     = res_acc_q;
  assign entry_count_o  = count_ext[OCNT_W-1:0];

endmodule : bounded_integer_set_table
`default_nettype wire

[rtl/core/bist_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bist_checker
// Port-level checks for the bounded integer set table, bound to the top.
// ----------------------------------------------------------------------------
module bist_checker import bist_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              action_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    result_valid_o,
  input  logic                    was_present_o,
  input  logic                    accepted_o,
  input  logic [OCNT_W-1:0]       entry_count_o
);

  // A clear answers in the next cycle with an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_CLEAR)) |=>
      (result_valid_o && !was_present_o && !accepted_o && (entry_count_o == '0)))
    else $error("clear did not return an empty result");

  // No result while an operation is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result shown while busy");

  // A result always follows an accepted item or a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) || $past(start))) 
    else $error("result without a preceding item");

  // The count holds while idle with no item offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> $stable(entry_count_o))
    else $error("count moved while idle");

endmodule : bist_checker

bind bounded_integer_set_table bist_checker u_bist_checker (.*);
`default_nettype wire
